[rtl/tfc_pkg.sv]
`default_nettype none

package tfc_pkg;

  localparam int unsigned WordCount = 8;

  typedef enum logic [2:0] {
    VtString      = 3'd0,
    VtBool        = 3'd1,
    VtFloat       = 3'd2,
    VtSignedInt   = 3'd3,
    VtUnsignedInt = 3'd4
  } value_type_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_field;
  } in_item_t;

  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChExpLo = 8'h65;
  localparam logic [7:0] ChExpUp = 8'h45;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] CaseGap = 8'h20;

  // Length of each boolean word.
  function automatic logic [2:0] word_len(input logic [2:0] k);
    logic [2:0] len;
    case (k)
      3'd0:    len = 3'd4;
      3'd1:    len = 3'd5;
      3'd2:    len = 3'd1;
      3'd3:    len = 3'd1;
      3'd4:    len = 3'd3;
      3'd5:    len = 3'd2;
      3'd6:    len = 3'd3;
      default: len = 3'd2;
    endcase
    return len;
  endfunction

  // Character of a boolean word at a position; lowest byte is the first character.
  function automatic logic [7:0] word_char(input logic [2:0] k, input logic [2:0] pos);
    logic [7:0][7:0] chars;
    case (k)
      3'd0:    chars = {24'h0, 8'h00, "e", "u", "r", "t"};
      3'd1:    chars = {24'h0, "e", "s", "l", "a", "f"};
      3'd2:    chars = {24'h0, 8'h00, 8'h00, 8'h00, 8'h00, "1"};
      3'd3:    chars = {24'h0, 8'h00, 8'h00, 8'h00, 8'h00, "0"};
      3'd4:    chars = {24'h0, 8'h00, 8'h00, "s", "e", "y"};
      3'd5:    chars = {24'h0, 8'h00, 8'h00, 8'h00, "o", "n"};
      3'd6:    chars = {24'h0, 8'h00, 8'h00, "f", "f", "o"};
      default: chars = {24'h0, 8'h00, 8'h00, 8'h00, "n", "o"};
    endcase
    return chars[pos];
  endfunction

endpackage

`default_nettype wire

[rtl/tfc_if.sv]
`default_nettype none

interface tfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  logic       empty_field;

  modport source (output valid, output char_code, output last_char, output empty_field,
                  input ready);
  modport sink (input valid, input char_code, input last_char, input empty_field,
                output ready);
endinterface

interface tfc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] value_type;

  modport source (output valid, output value_type, input ready);
  modport sink (input valid, input value_type, output ready);
endinterface

`default_nettype wire

[rtl/tfc_in_reg.sv]
`default_nettype none

module tfc_in_reg
  import tfc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tfc_in_if.sink        in_i,
  output logic          item_valid_o,
  output in_item_t      item_o,
  input  wire logic     item_ready_i
);

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;
  logic     load;

  assign in_i.ready = !valid_q || item_ready_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{char_code: in_i.char_code, last_char: in_i.last_char,
                  empty_field: in_i.empty_field};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

[rtl/tfc_classify.sv]
`default_nettype none

module tfc_classify
  import tfc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     item_valid_i,
  input  wire in_item_t item_i,
  output logic          item_ready_o,
  tfc_out_if.source     out_o
);

  logic [2:0]           pos_q, pos_d;
  logic [WordCount-1:0] mask_q, mask_d;
  logic                 lead_sign_q, lead_sign_d;
  logic                 lead_minus_q, lead_minus_d;
  logic                 dot_q, dot_d;
  logic                 exp_q, exp_d;
  logic                 mant_dig_q, mant_dig_d;
  logic                 exp_sign_ok_q, exp_sign_ok_d;
  logic                 exp_dig_q, exp_dig_d;
  logic                 invalid_q, invalid_d;
  logic                 out_valid_q, out_valid_d;
  value_type_e          code_q, code_d;

  logic [7:0]           c;
  logic [7:0]           low;
  logic                 is_digit;
  logic                 is_sign;
  logic                 bool_hit;
  logic                 ends_field;
  logic                 fire;

  assign c          = item_i.char_code;
  assign low        = (c >= ChUpA && c <= ChUpZ) ? c + CaseGap : c;
  assign is_digit   = (c >= ChZero) && (c <= ChNine);
  assign is_sign    = (c == ChPlus) || (c == ChMinus);
  assign ends_field = item_i.last_char || item_i.empty_field;

  // A byte waits only when it ends the field and a result still waits in the output register.
  assign item_ready_o = !ends_field || !out_valid_q || out_o.ready;
  assign fire         = item_valid_i && item_ready_o;

  always_comb begin
    pos_d         = pos_q;
    mask_d        = mask_q;
    lead_sign_d   = lead_sign_q;
    lead_minus_d  = lead_minus_q;
    dot_d         = dot_q;
    exp_d         = exp_q;
    mant_dig_d    = mant_dig_q;
    exp_sign_ok_d = exp_sign_ok_q;
    exp_dig_d     = exp_dig_q;
    invalid_d     = invalid_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    code_d        = code_q;
    bool_hit      = 1'b0;

    for (int k = 0; k < WordCount; k++) begin
      if (mask_q[k] && (pos_q < word_len(3'(k))) && (low == word_char(3'(k), pos_q))) begin
        if (pos_q + 3'd1 == word_len(3'(k))) begin
          bool_hit = 1'b1;
        end
      end else begin
        mask_d[k] = 1'b0;
      end
    end

    if (pos_q == 3'd0 && is_sign) begin
      lead_sign_d  = 1'b1;
      lead_minus_d = (c == ChMinus);
    end else if (exp_sign_ok_q && is_sign) begin
      exp_sign_ok_d = 1'b0;
    end else begin
      exp_sign_ok_d = 1'b0;
      if (c == ChDot) begin
        if (dot_q || exp_q) begin
          invalid_d = 1'b1;
        end
        dot_d = 1'b1;
      end else if (c == ChExpLo || c == ChExpUp) begin
        if (exp_q || !mant_dig_q) begin
          invalid_d = 1'b1;
        end
        exp_d         = 1'b1;
        exp_sign_ok_d = 1'b1;
      end else if (is_digit) begin
        if (exp_q) begin
          exp_dig_d = 1'b1;
        end else begin
          mant_dig_d = 1'b1;
        end
      end else begin
        invalid_d = 1'b1;
      end
    end

    if (pos_q != 3'd7) begin
      pos_d = pos_q + 3'd1;
    end

    if (bool_hit) begin
      code_d = VtBool;
    end else if (invalid_d || (exp_d && !exp_dig_d)) begin
      code_d = VtString;
    end else if (dot_d || exp_d) begin
      code_d = VtFloat;
    end else if (lead_sign_d && lead_minus_d) begin
      code_d = VtSignedInt;
    end else begin
      code_d = VtUnsignedInt;
    end

    if (item_i.empty_field) begin
      code_d = VtString;
    end

    if (!fire) begin
      pos_d         = pos_q;
      mask_d        = mask_q;
      lead_sign_d   = lead_sign_q;
      lead_minus_d  = lead_minus_q;
      dot_d         = dot_q;
      exp_d         = exp_q;
      mant_dig_d    = mant_dig_q;
      exp_sign_ok_d = exp_sign_ok_q;
      exp_dig_d     = exp_dig_q;
      invalid_d     = invalid_q;
      code_d        = code_q;
    end else if (ends_field) begin
      // The field is complete, so every flag goes back to its start value.
      pos_d         = 3'd0;
      mask_d        = '1;
      lead_sign_d   = 1'b0;
      lead_minus_d  = 1'b0;
      dot_d         = 1'b0;
      exp_d         = 1'b0;
      mant_dig_d    = 1'b0;
      exp_sign_ok_d = 1'b0;
      exp_dig_d     = 1'b0;
      invalid_d     = 1'b0;
      out_valid_d   = 1'b1;
    end else begin
      code_d = code_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= 3'd0;
      mask_q        <= '1;
      lead_sign_q   <= 1'b0;
      lead_minus_q  <= 1'b0;
      dot_q         <= 1'b0;
      exp_q         <= 1'b0;
      mant_dig_q    <= 1'b0;
      exp_sign_ok_q <= 1'b0;
      exp_dig_q     <= 1'b0;
      invalid_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      pos_q         <= pos_d;
      mask_q        <= mask_d;
      lead_sign_q   <= lead_sign_d;
      lead_minus_q  <= lead_minus_d;
      dot_q         <= dot_d;
      exp_q         <= exp_d;
      mant_dig_q    <= mant_dig_d;
      exp_sign_ok_q <= exp_sign_ok_d;
      exp_dig_q     <= exp_dig_d;
      invalid_q     <= invalid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.value_type = code_q;

endmodule

`default_nettype wire

[rtl/text_field_type_classifier.sv]
`default_nettype none
// Text field type classifier.
// The input channel carries one byte of a text field per transaction, with
// last_char marking the field's final byte and empty_field standing for a
// whole field of length zero. The output channel carries one value_type code
// per field: string, bool, float, signed int or unsigned int.
// Path: a byte accepted by the input channel is held in the input register,
// classified from there, and its result (if it ends a field) is captured in
// the output register, which drives the output channel.
// Throughput: one byte per cycle unless held as below; per-byte work is a flag
// update and an eight-word comparison between input and result registers.
// When the receiver stalls, the result stays in the output register and
// bytes that do not end a field keep flowing; a byte that ends a field waits
// in the input register until the result ahead of it is taken.
// Reset clears both valid bits and returns the field state to its start, so
// any partly received field is dropped.
module text_field_type_classifier
  import tfc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tfc_in_if.sink    in_i,
  tfc_out_if.source out_o
);

  logic     item_valid;
  logic     item_ready;
  in_item_t item;

  tfc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  tfc_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );

`ifndef SYNTHESIS
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.value_type <= 3'd4))
    else $error("value_type code out of range");

  a_empty_gives_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && item_ready && item.empty_field) |=>
      (out_o.valid && out_o.value_type == VtString))
    else $error("empty field did not give a string result");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && !item_ready) |-> (out_o.valid && !out_o.ready))
    else $error("classifier stalled with a free output register");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
  import tfc_pkg::*;

  logic clk_i;
  logic rst_ni;

  tfc_in_if  in_if ();
  tfc_out_if out_if ();

  text_field_type_classifier DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Boolean words, compared after folding upper case to lower case.
  string bool_words[WordCount] = '{"true", "false", "1", "0", "yes", "no", "off", "on"};

  // Classifier state kept by the testbench.
  logic [2:0] char_pos;
  logic [WordCount-1:0] word_mask;
  bit lead_sign, lead_minus, dot_seen, exp_seen, mant_digit, exp_sign_ok, exp_digit, bad_form;

  value_type_e expected_types[$];
  logic [7:0] field_bytes[$];
  bit steady_flow;
  int mismatches;
  int bytes_sent;
  int fields_sent;
  int type_seen[5];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void clear_field_state();
    char_pos    = '0;
    word_mask   = '1;
    lead_sign   = 1'b0;
    lead_minus  = 1'b0;
    dot_seen    = 1'b0;
    exp_seen    = 1'b0;
    mant_digit  = 1'b0;
    exp_sign_ok = 1'b0;
    exp_digit   = 1'b0;
    bad_form    = 1'b0;
  endfunction

  // Updates the field state for one byte; returns 1 when the byte yields a type code.
  function automatic bit classify_byte(input logic [7:0] c, input logic last,
                                       input logic empty, output value_type_e code);
    logic [7:0] low;
    bit is_digit;
    bit is_sign;
    bit word_hit;
    code     = VtString;
    word_hit = 1'b0;
    if (empty) begin
      clear_field_state();
      return 1'b1;
    end
    low      = (c >= ChUpA && c <= ChUpZ) ? c + CaseGap : c;
    is_digit = (c >= ChZero && c <= ChNine);
    is_sign  = (c == ChPlus || c == ChMinus);

    for (int k = 0; k < WordCount; k++) begin
      if (word_mask[k]) begin
        if (char_pos < bool_words[k].len() && low == bool_words[k][char_pos]) begin
          if (char_pos + 1 == bool_words[k].len()) word_hit = 1'b1;
        end else begin
          word_mask[k] = 1'b0;
        end
      end
    end

    if (char_pos == 3'd0 && is_sign) begin
      lead_sign  = 1'b1;
      lead_minus = (c == ChMinus);
    end else if (exp_sign_ok && is_sign) begin
      exp_sign_ok = 1'b0;
    end else begin
      exp_sign_ok = 1'b0;
      if (c == ChDot) begin
        if (dot_seen || exp_seen) bad_form = 1'b1;
        dot_seen = 1'b1;
      end else if (c == ChExpLo || c == ChExpUp) begin
        if (exp_seen || !mant_digit) bad_form = 1'b1;
        exp_seen    = 1'b1;
        exp_sign_ok = 1'b1;
      end else if (is_digit) begin
        if (exp_seen) exp_digit = 1'b1;
        else mant_digit = 1'b1;
      end else begin
        bad_form = 1'b1;
      end
    end

    if (char_pos != 3'd7) char_pos = char_pos + 3'd1;
    if (!last) return 1'b0;

    if (word_hit) code = VtBool;
    else if (bad_form || (exp_seen && !exp_digit)) code = VtString;
    else if (dot_seen || exp_seen) code = VtFloat;
    else if (lead_sign && lead_minus) code = VtSignedInt;
    else code = VtUnsignedInt;
    clear_field_state();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // The valid line stays high between back-to-back transactions and is only
  // lowered when the sender idles.
  task automatic send_byte(input logic [7:0] c, input logic last, input logic empty);
    value_type_e code;
    if (!steady_flow && $urandom_range(0, 99) < 32) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.char_code   <= c;
    in_if.last_char   <= last;
    in_if.empty_field <= empty;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    if (classify_byte(c, last, empty, code)) expected_types.push_back(code);
  endtask

  task automatic send_field();
    if (field_bytes.size() == 0) begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      foreach (field_bytes[i]) send_byte(field_bytes[i], i == field_bytes.size() - 1, 1'b0);
    end
    fields_sent++;
  endtask

  task automatic send_text(input string s);
    field_bytes.delete();
    for (int i = 0; i < s.len(); i++) field_bytes.push_back(s[i]);
    send_field();
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_types.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_digits(input int n);
    repeat (n) field_bytes.push_back(ChZero + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_sign();
    field_bytes.push_back($urandom_range(0, 1) ? ChMinus : ChPlus);
  endtask

  task automatic build_number();
    case ($urandom_range(0, 2))
      0: ;
      1: field_bytes.push_back(ChPlus);
      default: field_bytes.push_back(ChMinus);
    endcase
    add_digits($urandom_range(0, 4));
    if ($urandom_range(0, 2) == 0) begin
      field_bytes.push_back(ChDot);
      add_digits($urandom_range(0, 3));
    end
    if ($urandom_range(0, 3) == 0) begin
      field_bytes.push_back($urandom_range(0, 1) ? ChExpUp : ChExpLo);
      if ($urandom_range(0, 1)) add_sign();
      add_digits($urandom_range(0, 3));
    end
  endtask

  task automatic build_random_field();
    string word;
    logic [7:0] c;
    int pick;
    field_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      word = bool_words[$urandom_range(0, WordCount - 1)];
      for (int i = 0; i < word.len(); i++) begin
        c = word[i];
        if (c - CaseGap >= ChUpA && c - CaseGap <= ChUpZ && $urandom_range(0, 1)) c = c - CaseGap;
        field_bytes.push_back(c);
      end
      // Sometimes spoil the word with an extra byte.
      if ($urandom_range(0, 3) == 0) field_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 65) begin
      build_number();
    end else if (pick < 80) begin
      build_number();
      c = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
        0: c = ChDot;
        1: c = ChExpLo;
        2: c = ChPlus;
        3: c = ChMinus;
        default: ;
      endcase
      field_bytes.insert($urandom_range(0, field_bytes.size()), c);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 6)) field_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      if ($urandom_range(0, 1)) add_sign();
      add_digits($urandom_range(8, 16));
      if ($urandom_range(0, 1)) begin
        field_bytes.push_back(ChDot);
        add_digits($urandom_range(1, 4));
      end
    end
    // Otherwise the field stays empty.
  endtask

  task automatic test_bool_words();
    send_text("tRuE");
    send_text("0");
    send_text("On");
    wait_drained();
  endtask

  task automatic test_number_forms();
    send_text("+");
    send_text("-");
    send_text("-.");
    send_text("007");
    send_text("1E-5");
    send_text("1e");
    wait_drained();
  endtask

  task automatic test_empty_and_odd_bytes();
    send_byte(8'hff, 1'b1, 1'b1);
    // A field cut short by an empty-field item.
    send_byte(ChZero + 8'd1, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_text("-123456789.5");
    wait_drained();
  endtask

  task automatic test_random_fields(input int target_bytes);
    int stop_at;
    stop_at = bytes_sent + target_bytes;
    while (bytes_sent < stop_at) begin
      build_random_field();
      if (field_bytes.size() > 1 && $urandom_range(0, 19) == 0) begin
        foreach (field_bytes[i]) send_byte(field_bytes[i], 1'b0, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        fields_sent++;
      end else begin
        send_field();
      end
    end
    wait_drained();
  endtask

  task automatic test_back_to_back(input int target_bytes);
    steady_flow = 1'b1;
    test_random_fields(target_bytes);
    steady_flow = 1'b0;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_types.size() == 0) begin
        report_mismatch($sformatf("unexpected result value_type=%0d", out_if.value_type));
      end else begin
        if (out_if.value_type !== expected_types[0]) begin
          report_mismatch($sformatf("value_type expected %0d, got %0d",
                                    expected_types[0], out_if.value_type));
        end
        type_seen[expected_types[0]]++;
        void'(expected_types.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= steady_flow || ($urandom_range(0, 99) >= 32);
  end

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.char_code   = '0;
    in_if.last_char   = 1'b0;
    in_if.empty_field = 1'b0;
    out_if.ready      = 1'b0;
    steady_flow       = 1'b0;
    mismatches        = 0;
    bytes_sent        = 0;
    fields_sent       = 0;
    clear_field_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bool_words();
    test_number_forms();
    test_empty_and_odd_bytes();
    test_random_fields(450);
    test_back_to_back(200);
    test_random_fields(250);

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (expected_types.size() != 0) report_mismatch("results still outstanding at the end");

    $display("Sent %0d fields in %0d transactions, with random idling and a stall-free stretch.",
             fields_sent, bytes_sent);
    $display("Checked types: string %0d, bool %0d, float %0d, signed %0d, unsigned %0d.",
             type_seen[VtString], type_seen[VtBool], type_seen[VtFloat],
             type_seen[VtSignedInt], type_seen[VtUnsignedInt]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
